/* src/sctc_pkg.sv */
package sctc_pkg;

  localparam int unsigned CHANNELS_DEF     = 15;
  localparam int unsigned COUNTER_BITS_DEF = 16;
  localparam int unsigned TIME_W           = 64;
  localparam int unsigned IDEAL_W          = 32;
  localparam int unsigned PROD_W           = 96;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned CFG_IDX_W        = 2;

  localparam logic [IDEAL_W-1:0] IDEAL_RESET = 32'd85000000;

  // Operation codes
  localparam logic [1:0] OP_CAPTURE      = 2'd0;
  localparam logic [1:0] OP_CAPTURE_WRAP = 2'd1;
  localparam logic [1:0] OP_WRAP_PREP    = 2'd2;
  localparam logic [1:0] OP_WRAP_COMMIT  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDEAL_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDEAL_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_CH    = 2'd2;

  localparam logic [1:0] PHASE_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  channel_index;
    logic [15:0] capture_value;
    logic [15:0] counter_now;
    logic        pin_level;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  source_channel;
    logic [62:0] timestamp;
    logic        level_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  // Divider control
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

/* src/sctc_scale.sv */
// Bit-serial scale unit: product ideal*delta built by shift-add over the
// ideal bits (one bit per cycle), then a restoring divide by meas, one
// quotient bit per cycle over the 96-bit product.
module sctc_scale (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [sctc_pkg::IDEAL_W-1:0]       ideal,
  input  logic [sctc_pkg::TIME_W-1:0]        delta,
  input  logic [sctc_pkg::TIME_W-1:0]        meas,
  output sctc_pkg::div_ctl_t                 ctl,
  output logic [sctc_pkg::TIME_W-1:0]        quot
);

  localparam int unsigned CNT_W = 7;

  logic                               mul_r, mul_nxt;
  logic                               div_r, div_nxt;
  logic                               done_r, done_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [sctc_pkg::IDEAL_W-1:0]       ideal_r, ideal_nxt;
  logic [sctc_pkg::PROD_W-1:0]        prod_r, prod_nxt;
  logic [sctc_pkg::TIME_W-1:0]        meas_r, meas_nxt;
  logic [sctc_pkg::TIME_W-1:0]        rem_r, rem_nxt;
  logic [sctc_pkg::TIME_W-1:0]        quot_r, quot_nxt;
  logic [sctc_pkg::TIME_W:0]          rem_sh;
  logic [sctc_pkg::TIME_W:0]          rem_sub;

  // Shifted remainder and trial subtract
  assign rem_sh  = {rem_r, prod_r[sctc_pkg::PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, meas_r};

  always_comb begin
    mul_nxt   = mul_r;
    div_nxt   = div_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    ideal_nxt = ideal_r;
    prod_nxt  = prod_r;
    meas_nxt  = meas_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    if (start) begin
      mul_nxt   = 1'b1;
      cnt_nxt   = '0;
      ideal_nxt = ideal;
      prod_nxt  = '0;
      meas_nxt  = meas;
    end else if (mul_r) begin
      // MSB-first shift-add of delta
      prod_nxt  = {prod_r[sctc_pkg::PROD_W-2:0], 1'b0}
                + (ideal_r[sctc_pkg::IDEAL_W-1] ? {32'd0, delta} : '0);
      ideal_nxt = {ideal_r[sctc_pkg::IDEAL_W-2:0], 1'b0};
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(sctc_pkg::IDEAL_W - 1)) begin
        mul_nxt = 1'b0;
        div_nxt = 1'b1;
        cnt_nxt = '0;
        rem_nxt = '0;
        quot_nxt = '0;
      end
    end else if (div_r) begin
      prod_nxt = {prod_r[sctc_pkg::PROD_W-2:0], 1'b0};
      if (rem_sh[sctc_pkg::TIME_W] || !rem_sub[sctc_pkg::TIME_W]) begin
        rem_nxt  = rem_sub[sctc_pkg::TIME_W-1:0];
        quot_nxt = {quot_r[sctc_pkg::TIME_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[sctc_pkg::TIME_W-1:0];
        quot_nxt = {quot_r[sctc_pkg::TIME_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(sctc_pkg::PROD_W - 1)) begin
        div_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      div_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      div_r  <= div_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    ideal_r <= ideal_nxt;
    prod_r  <= prod_nxt;
    meas_r  <= meas_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy  = mul_r | div_r;
  assign ctl.done  = done_r;
  assign quot      = quot_r;

  // Never multiplying and dividing at once
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(mul_r && div_r))
    else $error("scale unit in two phases");
  // Divide follows the last multiply step
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_r && !start && cnt_r == CNT_W'(sctc_pkg::IDEAL_W - 1)) |=> div_r)
    else $error("divide did not start");
  // Done is a single pulse after the divide
  a_done: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !$past(done_r))
    else $error("done held");

endmodule

/* src/sync_corrected_timestamp_capture_core.sv */
// Channel  | Direction | Handshake          | Beat
// in_      | input     | in_valid/in_ready  | sctc_pkg::in_item_t
// out_     | output    | out_valid/out_ready| sctc_pkg::out_item_t
// cfg_     | input     | cfg_we             | cfg_idx, cfg_data
//
// Wrap events only update coarse state on accept; an uncorrected capture goes from
// accept to the output register load in ST_OUT.
// A corrected capture goes through the kick, the multiply steps, the divide steps,
// done, finish and the output load before out_valid, driven by the bit-serial
// multiply/divide unit; in_ready comes back in the same cycle as out_valid.
// rst_n is synchronous; it clears control and sync/coarse state.
// One item at a time: in_ready is low while an item is in work or waits in ST_OUT.
module sync_corrected_timestamp_capture_core #(
  parameter int unsigned CHANNELS     = sctc_pkg::CHANNELS_DEF,
  parameter int unsigned COUNTER_BITS = sctc_pkg::COUNTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sctc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sctc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [sctc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [sctc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned TW = sctc_pkg::TIME_W;
  // Captured count bits actually carried by the beat
  localparam int unsigned CAP_W = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;

  sctc_pkg::state_t            state_r, state_nxt;
  logic [sctc_pkg::IDEAL_W-1:0] ideal_hi_r, ideal_lo_r;
  logic [3:0]                  sync_ch_r;
  logic [TW-1:0]               coarse_r, next_coarse_r, last_r, meas_hi_r, meas_lo_r;
  logic [1:0]                  phase_r, edge_cnt_r;
  logic [TW-1:0]               t_r, t_nxt;
  logic [3:0]                  ch_r;
  logic                        lvl_r;
  logic                        neg_r;
  logic [TW-1:0]               base_r;
  sctc_pkg::out_item_t         out_r;
  logic                        out_valid_r;

  logic                        acc;
  logic                        ch_ok;
  logic [CAP_W-1:0]            cap_m, now_m;
  logic [TW-1:0]               t_cap;
  logic                        is_sync, corr;
  logic [sctc_pkg::IDEAL_W-1:0] ideal_sel;
  logic [TW-1:0]               meas_sel, delta;
  logic                        start;
  sctc_pkg::div_ctl_t          sctl;
  logic [TW-1:0]               quot;

  assign acc   = in_valid && in_ready;
  assign ch_ok = {3'b0, in_data.channel_index} < 7'(CHANNELS);
  assign cap_m = in_data.capture_value[CAP_W-1:0];
  assign now_m = in_data.counter_now[CAP_W-1:0];

  // Extend the captured count with the right coarse value
  always_comb begin
    if (in_data.operation == sctc_pkg::OP_CAPTURE_WRAP && cap_m < now_m)
      t_cap = next_coarse_r + TW'(cap_m);
    else
      t_cap = coarse_r + TW'(cap_m);
  end

  assign is_sync   = in_data.channel_index == sync_ch_r;
  assign ideal_sel = (phase_r == 2'd0) ? ideal_lo_r : ideal_hi_r;
  assign meas_sel  = (phase_r == 2'd0) ? meas_lo_r : meas_hi_r;
  assign corr      = !is_sync && phase_r != sctc_pkg::PHASE_UNKNOWN && meas_sel != '0;
  assign delta     = (t_r >= last_r) ? t_r - last_r : last_r - t_r;
  assign start     = (state_r == sctc_pkg::ST_MUL);

  sctc_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ideal (ideal_sel),
    .delta (delta),
    .meas  (meas_sel),
    .ctl   (sctl),
    .quot  (quot)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sctc_pkg::ST_IDLE: begin
        if (acc && ch_ok && (in_data.operation == sctc_pkg::OP_CAPTURE ||
                             in_data.operation == sctc_pkg::OP_CAPTURE_WRAP))
          state_nxt = corr ? sctc_pkg::ST_MUL : sctc_pkg::ST_OUT;
      end
      sctc_pkg::ST_MUL: state_nxt = sctc_pkg::ST_DIV;
      sctc_pkg::ST_DIV: if (sctl.done) state_nxt = sctc_pkg::ST_FIN;
      sctc_pkg::ST_FIN: state_nxt = sctc_pkg::ST_OUT;
      sctc_pkg::ST_OUT: if (!out_valid_r || out_ready) state_nxt = sctc_pkg::ST_IDLE;
      default: state_nxt = sctc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready = (state_r == sctc_pkg::ST_IDLE);
    t_nxt    = t_r;
    case (state_r)
      sctc_pkg::ST_IDLE: t_nxt = t_cap;
      sctc_pkg::ST_FIN:  t_nxt = neg_r ? base_r - quot : base_r + quot;
      default: t_nxt = t_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sctc_pkg::ST_IDLE;
      ideal_hi_r    <= sctc_pkg::IDEAL_RESET;
      ideal_lo_r    <= sctc_pkg::IDEAL_RESET;
      sync_ch_r     <= '0;
      coarse_r      <= '0;
      next_coarse_r <= '0;
      last_r        <= '0;
      meas_hi_r     <= '0;
      meas_lo_r     <= '0;
      phase_r       <= sctc_pkg::PHASE_UNKNOWN;
      edge_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          sctc_pkg::REG_IDEAL_HIGH: ideal_hi_r <= cfg_data;
          sctc_pkg::REG_IDEAL_LOW:  ideal_lo_r <= cfg_data;
          sctc_pkg::REG_SYNC_CH:    sync_ch_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (acc) begin
        case (in_data.operation)
          sctc_pkg::OP_WRAP_PREP:
            next_coarse_r <= coarse_r + (TW'(1) << COUNTER_BITS);
          sctc_pkg::OP_WRAP_COMMIT: coarse_r <= next_coarse_r;
          default: begin
            if (ch_ok && is_sync) begin
              if (in_data.pin_level) meas_lo_r <= t_cap - last_r;
              else meas_hi_r <= t_cap - last_r;
              last_r <= t_cap;
              if (edge_cnt_r >= 2'd2) phase_r <= {1'b0, in_data.pin_level};
              else edge_cnt_r <= edge_cnt_r + 2'd1;
            end
          end
        endcase
      end
      if (state_r == sctc_pkg::ST_OUT && (!out_valid_r || out_ready))
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
    t_r <= t_nxt;
    if (acc) begin
      ch_r <= in_data.channel_index;
      lvl_r <= in_data.pin_level;
    end
    if (state_r == sctc_pkg::ST_MUL) begin
      neg_r  <= t_r < last_r;
      base_r <= last_r;
    end
    if (state_r == sctc_pkg::ST_OUT && (!out_valid_r || out_ready)) begin
      out_r.source_channel <= ch_r;
      out_r.timestamp      <= t_r[62:0];
      out_r.level_out      <= lvl_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Input taken only when idle
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> state_r == sctc_pkg::ST_IDLE)
    else $error("accept outside idle");
  // Scale unit is busy throughout the divide wait until done
  a_kick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sctc_pkg::ST_DIV && !sctl.done) |-> sctl.busy)
    else $error("scale unit idle while waiting");
  // Sync phase only armed after two counted edges
  a_arm: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != sctc_pkg::PHASE_UNKNOWN |-> edge_cnt_r == 2'd2)
    else $error("armed early");

endmodule
